// ===== rtl/core/cch_pkg.sv =====
// Shared types, codes and default sizes of the class-conditional histogram.
package cch_pkg;

	localparam int unsigned DEF_BANDS       = 7;
	localparam int unsigned DEF_MAX_VALUES  = 256;
	localparam int unsigned DEF_MAX_CLASSES = 16;
	localparam int unsigned DEF_VALUE_BITS  = 16;
	localparam int unsigned DEF_COUNT_BITS  = 32;

	localparam int unsigned CFG_INDEX_BITS = 3;
	localparam int unsigned CFG_DATA_BITS  = 9;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_CLASS_COUNT = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_VALUES_BAND0 = 3'd1;

	typedef enum logic [1:0] {
		REQ_LOAD_GREY  = 2'd0,
		REQ_LOAD_LABEL = 2'd1,
		REQ_PIXEL      = 2'd2,
		REQ_READ       = 2'd3
	} req_kind_t;

	typedef struct packed {
		req_kind_t   req_type;
		logic [2:0]  band;
		logic [7:0]  entry_index;
		logic [3:0]  class_index;
		logic [15:0] entry_value;
		logic [15:0] pixel_value;
		logic [15:0] training_label;
	} in_item_t;

	typedef struct packed {
		logic [31:0] total_count;
		logic [31:0] class_hits;
		logic        pixel_skipped;
		logic        value_missing;
		logic        label_missing;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DISPATCH,
		ST_GREY,
		ST_LABEL,
		ST_READ,
		ST_TINC,
		ST_BOTH,
		ST_EMIT
	} cch_state_t;

endpackage

// ===== rtl/core/class_conditional_histogram.sv =====
// Top level of the class-conditional histogram: tables, count stores and sequencer.
//
//   channel   direction  payload      handshake
//   in        input      in_item_t    in_valid / in_stall
//   out       output     out_item_t   out_valid / out_stall
//   cfg       input      9-bit data   cfg_wr_en / cfg_index
//
// After reset the block sweeps both count stores to zero, one entry per cycle,
// through every address of the class store; no item is taken in that time. A
// load writes its table entry in ST_DISPATCH, and a read takes both counts in
// ST_READ. A pixel update searches the grey entries of its band and then the
// labels, with one-entry-per-cycle reads of the grey table and the label
// memory, and on a grey match increments the counts. Results sit in an output register, so
// the next transfer is taken while a result waits on out_stall.
module class_conditional_histogram
	import cch_pkg::*;
#(
	parameter int unsigned BANDS       = DEF_BANDS,
	parameter int unsigned MAX_VALUES  = DEF_MAX_VALUES,
	parameter int unsigned MAX_CLASSES = DEF_MAX_CLASSES,
	parameter int unsigned VALUE_BITS  = DEF_VALUE_BITS,
	parameter int unsigned COUNT_BITS  = DEF_COUNT_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  in_item_t                  in_data,
	output logic                      out_valid,
	input  logic                      out_stall,
	output out_item_t                 out_data,
	input  logic                      cfg_wr_en,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

	localparam int unsigned GDEPTH = BANDS * MAX_VALUES;
	localparam int unsigned CDEPTH = GDEPTH * MAX_CLASSES;
	localparam int unsigned GAW = (GDEPTH > 1) ? $clog2(GDEPTH) : 1;
	localparam int unsigned CAW = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
	localparam int unsigned LAW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
	localparam int unsigned BW  = (BANDS > 1) ? $clog2(BANDS) : 1;
	localparam int unsigned NW  = $clog2(MAX_VALUES + 1);
	localparam int unsigned MW  = $clog2(MAX_CLASSES + 1);

	typedef logic [VALUE_BITS-1:0] value_t;
	typedef logic [COUNT_BITS-1:0] count_t;

	// Configuration registers.
	logic [4:0]               class_count_q;
	logic [CFG_DATA_BITS-1:0] values_q [BANDS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			class_count_q <= '0;
			for (int b = 0; b < BANDS; b++) begin
				values_q[b] <= '0;
			end
		end else if (cfg_wr_en) begin
			if (cfg_index == CFG_CLASS_COUNT) begin
				class_count_q <= cfg_data[4:0];
			end else if (32'(cfg_index) >= 32'(CFG_VALUES_BAND0) &&
			             32'(cfg_index) - 32'(CFG_VALUES_BAND0) < BANDS) begin
				values_q[BW'(32'(cfg_index) - 32'(CFG_VALUES_BAND0))] <= cfg_data;
			end
		end
	end

	// Sequencer state and the item under work.
	cch_state_t state_q, state_d;
	in_item_t   req_q;
	out_item_t  res_q;
	logic [NW-1:0]  idx_q;
	logic [MW-1:0]  cls_q;
	logic [GAW-1:0] pos_q;
	logic [CAW-1:0] cpos_q;
	logic [CAW-1:0] clr_q;
	logic           out_valid_q;
	out_item_t      out_data_q;

	// Memory ports.
	logic           grey_we, lab_we, tot_we, cls_we;
	logic [GAW-1:0] grey_waddr, grey_raddr, tot_waddr, tot_raddr;
	logic [LAW-1:0] lab_waddr, lab_raddr;
	logic [CAW-1:0] cls_waddr, cls_raddr;
	count_t         tot_wdata, cls_wdata;
	value_t         grey_rdata_q, lab_rdata_q;
	count_t         tot_rdata_q, cls_rdata_q;

	value_t grey_mem [GDEPTH];
	value_t lab_mem  [MAX_CLASSES];
	count_t tot_mem  [GDEPTH];
	count_t cls_mem  [CDEPTH];

	always_ff @(posedge clk) begin
		if (grey_we) begin
			grey_mem[grey_waddr] <= value_t'(req_q.entry_value);
		end
		grey_rdata_q <= grey_mem[grey_raddr];
	end

	always_ff @(posedge clk) begin
		if (lab_we) begin
			lab_mem[lab_waddr] <= value_t'(req_q.entry_value);
		end
		lab_rdata_q <= lab_mem[lab_raddr];
	end

	always_ff @(posedge clk) begin
		if (tot_we) begin
			tot_mem[tot_waddr] <= tot_wdata;
		end
		tot_rdata_q <= tot_mem[tot_raddr];
	end

	always_ff @(posedge clk) begin
		if (cls_we) begin
			cls_mem[cls_waddr] <= cls_wdata;
		end
		cls_rdata_q <= cls_mem[cls_raddr];
	end

	// Decoded facts about the current item.
	logic          band_ok, ei_ok, ci_ok;
	logic [BW-1:0] band_sel;
	logic [NW-1:0] n_listed;
	logic [MW-1:0] m_used;
	logic [31:0]   gbase;
	value_t        pv, tl;
	logic [GAW-1:0] ld_pos, hit_pos;
	logic [CAW-1:0] rd_cpos, hit_cpos;
	logic           grey_match, lab_match;

	always_comb begin
		band_ok  = 32'(req_q.band) < BANDS;
		ei_ok    = 32'(req_q.entry_index) < MAX_VALUES;
		ci_ok    = 32'(req_q.class_index) < MAX_CLASSES;
		band_sel = band_ok ? BW'(req_q.band) : '0;
		n_listed = (32'(values_q[band_sel]) > MAX_VALUES) ? NW'(MAX_VALUES)
		                                                : NW'(values_q[band_sel]);
		m_used   = (32'(class_count_q) > MAX_CLASSES) ? MW'(MAX_CLASSES)
		                                            : MW'(class_count_q);
		gbase    = 32'(req_q.band) * MAX_VALUES;
		pv       = value_t'(req_q.pixel_value);
		tl       = value_t'(req_q.training_label);
		ld_pos   = GAW'(gbase + 32'(req_q.entry_index));
		hit_pos  = GAW'(gbase + 32'(idx_q));
		rd_cpos  = CAW'(32'(ld_pos) * MAX_CLASSES + 32'(req_q.class_index));
		hit_cpos = CAW'(32'(pos_q) * MAX_CLASSES + 32'(cls_q));
		grey_match = grey_rdata_q == pv;
		lab_match  = lab_rdata_q == tl;
	end

	logic emit_fire;

	// Next state and memory control.
	always_comb begin
		state_d    = state_q;
		grey_we    = 1'b0;
		lab_we     = 1'b0;
		tot_we     = 1'b0;
		cls_we     = 1'b0;
		grey_waddr = ld_pos;
		grey_raddr = GAW'(gbase + 32'(idx_q) + 32'd1);
		lab_waddr  = LAW'(req_q.class_index);
		lab_raddr  = LAW'(32'(cls_q) + 32'd1);
		tot_waddr  = pos_q;
		tot_raddr  = pos_q;
		tot_wdata  = (&tot_rdata_q) ? tot_rdata_q : tot_rdata_q + count_t'(1);
		cls_waddr  = cpos_q;
		cls_raddr  = cpos_q;
		cls_wdata  = (&cls_rdata_q) ? cls_rdata_q : cls_rdata_q + count_t'(1);
		emit_fire  = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cls_we    = 1'b1;
				cls_waddr = clr_q;
				cls_wdata = '0;
				tot_we    = 32'(clr_q) < GDEPTH;
				tot_waddr = GAW'(clr_q);
				tot_wdata = '0;
				if (32'(clr_q) == CDEPTH - 1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				grey_raddr = GAW'(gbase);
				tot_raddr  = ld_pos;
				cls_raddr  = rd_cpos;
				case (req_q.req_type)
					REQ_LOAD_GREY: begin
						grey_we = band_ok && ei_ok;
						state_d = ST_EMIT;
					end
					REQ_LOAD_LABEL: begin
						lab_we  = ci_ok;
						state_d = ST_EMIT;
					end
					REQ_PIXEL: begin
						if (pv == '0 || !band_ok || n_listed == '0) begin
							state_d = ST_EMIT;
						end else begin
							state_d = ST_GREY;
						end
					end
					REQ_READ: begin
						state_d = (band_ok && ei_ok) ? ST_READ : ST_EMIT;
					end
					default: state_d = ST_EMIT;
				endcase
			end
			ST_GREY: begin
				if (grey_match) begin
					tot_raddr = hit_pos;
					lab_raddr = '0;
					if (tl != '0 && m_used != '0) begin
						state_d = ST_LABEL;
					end else begin
						state_d = ST_TINC;
					end
				end else if (32'(idx_q) + 32'd1 == 32'(n_listed)) begin
					state_d = ST_EMIT;
				end
			end
			ST_LABEL: begin
				if (lab_match) begin
					cls_raddr = hit_cpos;
					state_d   = ST_BOTH;
				end else if (32'(cls_q) + 32'd1 == 32'(m_used)) begin
					state_d = ST_TINC;
				end
			end
			ST_READ: state_d = ST_EMIT;
			ST_TINC: begin
				tot_we  = 1'b1;
				state_d = ST_EMIT;
			end
			ST_BOTH: begin
				tot_we  = 1'b1;
				cls_we  = 1'b1;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (!out_valid_q || !out_stall) begin
					emit_fire = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + CAW'(1);
			end
		end
	end

	// Working registers of the item; payload only, no reset needed.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				req_q <= in_data;
				res_q <= '0;
			end
			ST_DISPATCH: begin
				idx_q  <= '0;
				cls_q  <= '0;
				pos_q  <= ld_pos;
				cpos_q <= rd_cpos;
				if (req_q.req_type == REQ_PIXEL) begin
					res_q.pixel_skipped <= pv == '0;
					res_q.value_missing <= pv != '0 && (!band_ok || n_listed == '0);
				end
			end
			ST_GREY: begin
				if (grey_match) begin
					pos_q <= hit_pos;
					res_q.label_missing <= tl != '0 && m_used == '0;
				end else begin
					idx_q <= idx_q + NW'(1);
					res_q.value_missing <= 32'(idx_q) + 32'd1 == 32'(n_listed);
				end
			end
			ST_LABEL: begin
				if (lab_match) begin
					cpos_q <= hit_cpos;
				end else begin
					cls_q <= cls_q + MW'(1);
					res_q.label_missing <= 32'(cls_q) + 32'd1 == 32'(m_used);
				end
			end
			ST_READ: begin
				res_q.total_count <= 32'(tot_rdata_q);
				res_q.class_hits  <= ci_ok ? 32'(cls_rdata_q) : '0;
			end
			default: ;
		endcase
	end

	// Output register: a finished result waits here while a new item is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			out_data_q <= res_q;
		end
	end

	assign in_stall  = state_q != ST_IDLE;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// ===== rtl/core/cch_checker.sv =====
// Port-level checks of the class-conditional histogram and their binding.
module cch_checker
	import cch_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_stall,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_data
);

	// A result that is held back stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// The block works on one item at a time.
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second transfer taken while busy");

	// A pixel outcome carries at most one of skipped, missing value or missing label.
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot0({out_data.pixel_skipped, out_data.value_missing,
		                        out_data.label_missing}))
		else $error("conflicting pixel flags");

	// Flags only come with pixel updates, which report no counts.
	a_flags_no_counts: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.pixel_skipped || out_data.value_missing ||
		              out_data.label_missing)
		|-> out_data.total_count == '0 && out_data.class_hits == '0)
		else $error("counts reported with a pixel flag");

endmodule

bind class_conditional_histogram cch_checker u_cch_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
